>>> sv/obp_pkg.sv
// shared types, constants and the pattern table for the blink pattern sequencer
// no dependencies
package obp_pkg;

   localparam int NUM_OUTPUTS_DEF = 4;
   localparam int PATTERN_ROM_DEPTH_DEF = 64;

   localparam int FUNC_W = 2;
   localparam int IDX_FIELD_W = 2;
   localparam int PID_W = 3;
   localparam int REQ_DATA_W = 8;
   localparam int RSP_FIELD_W = 4;
   localparam int RSP_DATA_W = 8;
   localparam int PERIOD_W = 10;
   localparam int DUR_W = 16;
   localparam int ROM_IDX_W = 6;
   localparam int ROM_USED = 48;
   localparam int NUM_PATTERNS = 7;

   typedef enum logic [FUNC_W-1:0] {
      FUNC_TICK  = 2'd0,
      FUNC_START = 2'd1,
      FUNC_CLEAR = 2'd2,
      FUNC_LEVEL = 2'd3
   } func_type;

   typedef enum logic [1:0] {
      KIND_TIMED = 2'd0,
      KIND_LOOP  = 2'd1,
      KIND_HOLD  = 2'd2
   } kind_type;

   typedef struct packed {
      logic             lvl;
      kind_type         kind;
      logic [DUR_W-1:0] dur;
   } entry_type;

   function automatic entry_type mk_entry(input logic lvl, input kind_type kind,
                                          input logic [DUR_W-1:0] dur);
      entry_type e;
      e.lvl  = lvl;
      e.kind = kind;
      e.dur  = dur;
      return e;
   endfunction

   // pattern table, reads past the used part give a low hold entry
   function automatic entry_type rom_lookup(input logic [ROM_IDX_W-1:0] idx);
      entry_type e;
      e = mk_entry(1'b0, KIND_HOLD, 16'd0);
      case (idx)
         6'd0: e = mk_entry(1'b1, KIND_TIMED, 16'd100);
         6'd1: e = mk_entry(1'b0, KIND_TIMED, 16'd200);
         6'd2, 6'd9, 6'd16: e = mk_entry(1'b0, KIND_LOOP, 16'd0);
         6'd3, 6'd17, 6'd19, 6'd21, 6'd23, 6'd25:
            e = mk_entry(1'b1, KIND_TIMED, 16'd10);
         6'd4: e = mk_entry(1'b1, KIND_HOLD, 16'd0);
         6'd5: e = mk_entry(1'b0, KIND_TIMED, 16'd10);
         6'd6, 6'd27, 6'd47: e = mk_entry(1'b0, KIND_HOLD, 16'd0);
         6'd7: e = mk_entry(1'b1, KIND_TIMED, 16'd30);
         6'd8: e = mk_entry(1'b0, KIND_TIMED, 16'd900);
         6'd10, 6'd12, 6'd14, 6'd28, 6'd30, 6'd32, 6'd34, 6'd36, 6'd38, 6'd40,
            6'd42, 6'd44, 6'd46:
            e = mk_entry(1'b1, KIND_TIMED, 16'd50);
         6'd11, 6'd13, 6'd29, 6'd31, 6'd33, 6'd35, 6'd37, 6'd39, 6'd41, 6'd43,
            6'd45:
            e = mk_entry(1'b0, KIND_TIMED, 16'd50);
         6'd15: e = mk_entry(1'b0, KIND_TIMED, 16'd250);
         6'd18, 6'd20, 6'd22, 6'd24, 6'd26:
            e = mk_entry(1'b0, KIND_TIMED, 16'd40);
         default: e = mk_entry(1'b0, KIND_HOLD, 16'd0);
      endcase
      return e;
   endfunction

   function automatic logic [ROM_IDX_W-1:0] pat_first(input logic [PID_W-1:0] pid);
      logic [ROM_IDX_W-1:0] f;
      f = 6'd0;
      case (pid)
         3'd0: f = 6'd0;
         3'd1: f = 6'd3;
         3'd2: f = 6'd5;
         3'd3: f = 6'd7;
         3'd4: f = 6'd10;
         3'd5: f = 6'd17;
         3'd6: f = 6'd28;
         default: f = 6'd0;
      endcase
      return f;
   endfunction

endpackage

>>> sv/obp_div.sv
// shared restoring divider, one quotient bit per cycle
// depends on obp_pkg
module obp_div (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [obp_pkg::DUR_W-1:0]    dividend,
   input  logic [obp_pkg::PERIOD_W-1:0] divisor,
   output logic                         done,
   output logic [obp_pkg::DUR_W-1:0]    quotient
);
   import obp_pkg::*;

   localparam int CNT_W = $clog2(DUR_W + 1);

   logic                active_ff;
   logic                done_ff;
   logic [CNT_W-1:0]    cnt_ff;
   logic [PERIOD_W-1:0] div_ff;
   logic [PERIOD_W-1:0] rem_ff;
   logic [DUR_W-1:0]    quo_ff;

   logic [PERIOD_W:0]   shifted;
   logic [PERIOD_W:0]   diff;
   logic                ge;
   logic [PERIOD_W-1:0] rem_in;
   logic [DUR_W-1:0]    quo_in;

   always_comb begin
      shifted = {rem_ff, quo_ff[DUR_W-1]};
      diff    = shifted - {1'b0, div_ff};
      ge      = shifted >= {1'b0, div_ff};
      rem_in  = ge ? diff[PERIOD_W-1:0] : shifted[PERIOD_W-1:0];
      quo_in  = {quo_ff[DUR_W-2:0], ge};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         done_ff   <= 1'b0;
         cnt_ff    <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            active_ff <= 1'b1;
            cnt_ff    <= CNT_W'(DUR_W);
            div_ff    <= (divisor == '0) ? PERIOD_W'(1) : divisor;
            rem_ff    <= '0;
            quo_ff    <= dividend;
         end else if (active_ff) begin
            rem_ff <= rem_in;
            quo_ff <= quo_in;
            cnt_ff <= cnt_ff - CNT_W'(1);
            if (cnt_ff == CNT_W'(1)) begin
               active_ff <= 1'b0;
               done_ff   <= 1'b1;
            end
         end
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

>>> sv/output_blink_pattern_sequencer.sv
// blink pattern sequencer top level: per-output state, sequencer and shared divider
// a start item passes the dispatch, load and divide states, a clear or level item only dispatch;
// a tick item walks every output and fetches, loads and divides for each output whose count expires
// requests are taken one at a time, only in the idle state, and wait on the shared divider and the output walk
// reset clears all outputs, counts and patterns and sets tick_period to 1
module output_blink_pattern_sequencer #(
   parameter int NUM_OUTPUTS       = obp_pkg::NUM_OUTPUTS_DEF,
   parameter int PATTERN_ROM_DEPTH = obp_pkg::PATTERN_ROM_DEPTH_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   // output_index, pattern_id, level, zero fill
   input  logic [obp_pkg::REQ_DATA_W-1:0] req_tdata,
   // func
   input  logic [obp_pkg::FUNC_W-1:0]     req_tuser,
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   // levels, running
   output logic [obp_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [obp_pkg::PERIOD_W-1:0]   csr_wdata
);
   import obp_pkg::*;

   localparam int IDX_W = (NUM_OUTPUTS > 1) ? $clog2(NUM_OUTPUTS) : 1;
   localparam int PTR_W = $clog2(PATTERN_ROM_DEPTH) + 1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DISPATCH,
      ST_TICK,
      ST_FETCH,
      ST_LOAD,
      ST_DIV,
      ST_DONE
   } state_type;

   state_type            state_ff;
   logic [PERIOD_W-1:0]  tick_period_ff;
   logic [FUNC_W-1:0]    func_ff;
   logic [PID_W-1:0]     pid_ff;
   logic                 lvl_bit_ff;
   logic                 idx_ok_ff;
   logic                 tick_mode_ff;
   logic [IDX_W-1:0]     cur_ff;
   logic [PTR_W-1:0]     load_addr_ff;
   logic                 rsp_tvalid_ff;
   logic [RSP_DATA_W-1:0] rsp_data_ff;

   logic                 level_ff [NUM_OUTPUTS];
   logic [DUR_W-1:0]     count_ff [NUM_OUTPUTS];
   logic [PTR_W-1:0]     ptr_ff   [NUM_OUTPUTS];
   logic [PTR_W-1:0]     start_ff [NUM_OUTPUTS];

   logic [PTR_W-1:0]     rom_addr;
   entry_type            rom_e;
   logic                 div_start;
   logic                 div_done;
   logic [DUR_W-1:0]     div_q;
   logic [RSP_FIELD_W-1:0] levels_vec;
   logic [RSP_FIELD_W-1:0] running_vec;
   logic [PTR_W-1:0]     first_ptr;
   logic                 last_out;

   assign req_tready = (state_ff == ST_IDLE);
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_data_ff;

   assign rom_addr  = (state_ff == ST_FETCH) ? ptr_ff[cur_ff] : load_addr_ff;
   assign div_start = (state_ff == ST_LOAD);
   assign first_ptr = PTR_W'(pat_first(pid_ff));
   assign last_out  = (cur_ff == IDX_W'(NUM_OUTPUTS - 1));

   always_comb begin
      if ((32'(rom_addr) < 32'(ROM_USED)) && (32'(rom_addr) < 32'(PATTERN_ROM_DEPTH))) begin
         rom_e = rom_lookup(rom_addr[ROM_IDX_W-1:0]);
      end else begin
         rom_e = mk_entry(1'b0, KIND_HOLD, 16'd0);
      end
   end

   genvar gi;
   generate
      for (gi = 0; gi < RSP_FIELD_W; gi++) begin : g_status
         if (gi < NUM_OUTPUTS) begin : g_used
            assign levels_vec[gi]  = level_ff[gi];
            assign running_vec[gi] = (count_ff[gi] != '0);
         end else begin : g_unused
            assign levels_vec[gi]  = 1'b0;
            assign running_vec[gi] = 1'b0;
         end
      end
   endgenerate

   obp_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (rom_e.dur),
      .divisor  (tick_period_ff),
      .done     (div_done),
      .quotient (div_q)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         tick_period_ff <= PERIOD_W'(1);
         rsp_tvalid_ff  <= 1'b0;
         cur_ff         <= '0;
         tick_mode_ff   <= 1'b0;
         for (int i = 0; i < NUM_OUTPUTS; i++) begin
            level_ff[i] <= 1'b0;
            count_ff[i] <= '0;
            ptr_ff[i]   <= '0;
            start_ff[i] <= '0;
         end
      end else begin
         if (csr_valid && csr_ready) begin
            tick_period_ff <= csr_wdata;
         end
         if (rsp_tready) begin
            rsp_tvalid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (req_tvalid) begin
                  func_ff    <= req_tuser;
                  cur_ff     <= IDX_W'(req_tdata[1:0]);
                  idx_ok_ff  <= (32'(req_tdata[1:0]) < 32'(NUM_OUTPUTS));
                  pid_ff     <= req_tdata[4:2];
                  lvl_bit_ff <= req_tdata[5];
                  state_ff   <= ST_DISPATCH;
               end
            end
            ST_DISPATCH: begin
               tick_mode_ff <= 1'b0;
               state_ff     <= ST_DONE;
               case (func_type'(func_ff))
                  FUNC_TICK: begin
                     tick_mode_ff <= 1'b1;
                     cur_ff       <= '0;
                     state_ff     <= ST_TICK;
                  end
                  FUNC_START: begin
                     if (idx_ok_ff && (32'(pid_ff) < 32'(NUM_PATTERNS)) &&
                         (start_ff[cur_ff] != first_ptr + PTR_W'(1))) begin
                        start_ff[cur_ff] <= first_ptr + PTR_W'(1);
                        load_addr_ff     <= first_ptr;
                        state_ff         <= ST_LOAD;
                     end
                  end
                  FUNC_CLEAR: begin
                     if (idx_ok_ff) begin
                        start_ff[cur_ff] <= '0;
                        ptr_ff[cur_ff]   <= '0;
                     end
                  end
                  FUNC_LEVEL: begin
                     if (idx_ok_ff) begin
                        level_ff[cur_ff] <= lvl_bit_ff;
                     end
                  end
                  default: state_ff <= ST_DONE;
               endcase
            end
            ST_TICK: begin
               if (count_ff[cur_ff] == '0 || count_ff[cur_ff] != DUR_W'(1) ||
                   start_ff[cur_ff] == '0) begin
                  if (count_ff[cur_ff] != '0) begin
                     count_ff[cur_ff] <= count_ff[cur_ff] - DUR_W'(1);
                     if (count_ff[cur_ff] == DUR_W'(1)) begin
                        level_ff[cur_ff] <= 1'b0;
                     end
                  end
                  if (last_out) begin
                     state_ff <= ST_DONE;
                  end else begin
                     cur_ff <= cur_ff + IDX_W'(1);
                  end
               end else begin
                  count_ff[cur_ff] <= '0;
                  state_ff         <= ST_FETCH;
               end
            end
            ST_FETCH: begin
               case (rom_e.kind)
                  KIND_HOLD: begin
                     level_ff[cur_ff] <= rom_e.lvl;
                     start_ff[cur_ff] <= '0;
                     ptr_ff[cur_ff]   <= ptr_ff[cur_ff] + PTR_W'(1);
                     if (last_out) begin
                        state_ff <= ST_DONE;
                     end else begin
                        cur_ff   <= cur_ff + IDX_W'(1);
                        state_ff <= ST_TICK;
                     end
                  end
                  KIND_LOOP: begin
                     load_addr_ff <= start_ff[cur_ff] - PTR_W'(1);
                     state_ff     <= ST_LOAD;
                  end
                  default: begin
                     load_addr_ff <= ptr_ff[cur_ff];
                     state_ff     <= ST_LOAD;
                  end
               endcase
            end
            ST_LOAD: begin
               level_ff[cur_ff] <= rom_e.lvl;
               ptr_ff[cur_ff]   <= load_addr_ff + PTR_W'(1);
               state_ff         <= ST_DIV;
            end
            ST_DIV: begin
               if (div_done) begin
                  count_ff[cur_ff] <= div_q;
                  if (tick_mode_ff && !last_out) begin
                     cur_ff   <= cur_ff + IDX_W'(1);
                     state_ff <= ST_TICK;
                  end else begin
                     state_ff <= ST_DONE;
                  end
               end
            end
            ST_DONE: begin
               if (!rsp_tvalid_ff || rsp_tready) begin
                  rsp_tvalid_ff <= 1'b1;
                  rsp_data_ff   <= {running_vec, levels_vec};
                  state_ff      <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

endmodule
